// ----- rtl/core/dslt_pkg.sv -----
// ---------------------------------------------------------------------------
// dslt_pkg
// Shared types, codes and fixed-point helpers of the dense sigmoid layer
// trainer.
// ---------------------------------------------------------------------------
package dslt_pkg;

  typedef enum logic [2:0] {
    OpLoadWeight = 3'd0,
    OpLoadBias   = 3'd1,
    OpForward    = 3'd2,
    OpOutError   = 3'd3,
    OpPrevAct    = 3'd4,
    OpReadError  = 3'd5,
    OpUpdate     = 3'd6
  } opcode_e;

  typedef enum logic [1:0] {
    CfgInSize    = 2'd0,
    CfgOutSize   = 2'd1,
    CfgLearnRate = 2'd2
  } cfg_idx_e;

  localparam int unsigned NodeCap = 16;
  localparam int unsigned RomSize = 1024;
  localparam int unsigned NumW    = 48;

  typedef enum logic [4:0] {
    StepNone,
    StepLatch,
    StepLoadW,
    StepLoadB,
    StepRdW,
    StepFwdMul,
    StepFwdAcc,
    StepFinZ,
    StepFinOut,
    StepFinClr,
    StepErrS,
    StepErrD,
    StepErrW,
    StepRdG,
    StepWgMul,
    StepWgAcc,
    StepBg,
    StepPeMul,
    StepPeAcc,
    StepPeOut,
    StepUpdRd,
    StepUpdMul,
    StepUpdDiv,
    StepUpdWr,
    StepGClr,
    StepBgClr
  } step_e;

  typedef struct packed {
    step_e       step;
    logic [5:0]  row;
    logic [6:0]  col;
    logic        flag;
    logic [4:0]  nout;
    logic [14:0] lr;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } status_t;

  typedef logic [15:0] sig_rom_t [RomSize];

  // shift and subtract quotient, evaluated at elaboration only
  function automatic longint unsigned udiv64(longint unsigned n, longint unsigned d);
    longint unsigned q;
    longint unsigned rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], n[b]};
      if (rem >= d) begin
        rem  = rem - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // sigmoid over [-8,8) in steps of 1/64
  function automatic sig_rom_t build_sig_rom(int unsigned frac);
    sig_rom_t rom;
    longint unsigned e;
    longint unsigned d;
    longint unsigned one;
    rom = '{default: '0};
    e   = 64'd1 << 30;
    one = 64'd1 << frac;
    for (int m = 0; m <= 512; m++) begin
      d = (64'd1 << 30) + e;
      if (m <= 511) rom[512 + m] = 16'(udiv64((one << 30) + (d >> 1), d));
      if (m >= 1) rom[512 - m] = 16'(udiv64(one * e + (d >> 1), d));
      e = (e * 64'd1057095000 + (64'd1 << 29)) >> 30;
    end
    return rom;
  endfunction

  function automatic logic signed [63:0] rnd_frac(logic signed [63:0] x, int unsigned frac);
    return (x + (64'sd1 <<< (frac - 1))) >>> frac;
  endfunction

  function automatic logic signed [15:0] sat16(logic signed [63:0] x);
    if (x > 64'sd32767) return 16'sh7fff;
    if (x < -64'sd32768) return 16'sh8000;
    return 16'(x);
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return 32'(x);
  endfunction

endpackage

// ----- rtl/core/dslt_div.sv -----
// ---------------------------------------------------------------------------
// dslt_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module dslt_div #(
  parameter int unsigned NUM_W = 48,
  parameter int unsigned DEN_W = 28
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [NUM_W-1:0] quo_o,
  output logic             done_o
);

  localparam int unsigned CntW = $clog2(NUM_W + 1);

  logic [CntW-1:0]  cnt_q;
  logic             done_q;
  logic [DEN_W:0]   rem_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;

  assign rem_sh = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
  assign diff   = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CntW'(NUM_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (cnt_q != '0) begin
      if (!diff[DEN_W]) begin
        rem_q <= diff;
        quo_q <= {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;

endmodule

// ----- rtl/core/dslt_datapath.sv -----
// ---------------------------------------------------------------------------
// dslt_datapath
// Weight and gradient memories, per-row state, shared product register and the
// result register.
// ---------------------------------------------------------------------------
module dslt_datapath #(
  parameter int unsigned IN_MAX    = 16,
  parameter int unsigned OUT_MAX   = 16,
  parameter int unsigned FRAC_BITS = 12
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dslt_pkg::cmd_t          cmd_i,
  output dslt_pkg::status_t       status_o,
  input  logic signed [15:0]      value_i,
  input  logic [15:0]             sample_count_i,
  output logic                    result_valid_o,
  output logic signed [15:0]      result_value_o,
  output logic [3:0]              result_index_o,
  output logic                    result_last_o
);
  import dslt_pkg::*;

  localparam int unsigned RW    = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1;
  localparam int unsigned Depth = OUT_MAX * IN_MAX;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned DenW  = 16 + FRAC_BITS;
  localparam int unsigned LimW  = FRAC_BITS + 5;
  localparam sig_rom_t SigRom   = build_sig_rom(FRAC_BITS);

  logic signed [15:0] wmem [Depth];
  logic signed [31:0] gmem [Depth];

  logic signed [15:0] bias_q  [OUT_MAX];
  logic signed [31:0] acc_q   [OUT_MAX];
  logic signed [15:0] z_q     [OUT_MAX];
  logic signed [15:0] delta_q [OUT_MAX];
  logic signed [31:0] bg_q    [OUT_MAX];

  logic signed [15:0] w_rd_q;
  logic signed [31:0] g_rd_q;
  logic signed [31:0] prod_q;
  logic signed [47:0] upd_p_q;
  logic signed [39:0] sum_q;
  logic signed [15:0] value_q;
  logic [15:0]        cnt_q;

  logic               res_valid_q;
  logic signed [15:0] res_value_q;
  logic [3:0]         res_index_q;
  logic               res_last_q;

  logic [RW-1:0]      r;
  logic [AW-1:0]      addr;
  logic               col_in;
  logic               col_bias;
  logic [15:0]        s_val;
  logic [31:0]        s_ext;
  logic signed [17:0] d_val;
  logic signed [31:0] g_sel;
  logic [NumW-1:0]    mag;
  logic [NumW-1:0]    num;
  logic [DenW-1:0]    den;
  logic [NumW-1:0]    quo;
  logic signed [49:0] qs;
  logic signed [15:0] old_w;
  logic signed [15:0] new_w;
  logic               w_we;
  logic               g_we;
  logic               div_start;
  logic               div_done;

  function automatic logic [15:0] sig_lookup(logic signed [15:0] z);
    logic signed [LimW-1:0] zw;
    logic signed [LimW-1:0] lim;
    logic [LimW-1:0]        off;
    lim = LimW'(1 << (FRAC_BITS + 3));
    zw  = LimW'(z);
    if (zw < -lim) zw = -lim;
    if (zw > lim - 1) zw = lim - 1;
    off = LimW'(zw + lim);
    return SigRom[10'(off >> (FRAC_BITS - 6))];
  endfunction

  assign r        = RW'(cmd_i.row);
  assign addr     = AW'(int'(cmd_i.row) * IN_MAX + int'(cmd_i.col));
  assign col_in   = cmd_i.col < 7'(IN_MAX);
  assign col_bias = cmd_i.col == 7'(IN_MAX);

  assign s_val = sig_lookup(z_q[r]);
  assign s_ext = 32'(s_val);
  assign d_val = 18'(rnd_frac(64'(prod_q), FRAC_BITS));
  assign g_sel = col_bias ? bg_q[r] : g_rd_q;

  assign mag = upd_p_q[47] ? NumW'(-upd_p_q) : NumW'(upd_p_q);
  assign num = mag + (NumW'(cnt_q) << (FRAC_BITS - 1));
  assign den = {cnt_q, {FRAC_BITS{1'b0}}};
  assign qs  = upd_p_q[47] ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
  assign old_w = col_bias ? bias_q[r] : w_rd_q;
  assign new_w = sat16(64'(old_w) - 64'(qs));

  assign w_we      = (cmd_i.step == StepLoadW) || ((cmd_i.step == StepUpdWr) && col_in);
  assign g_we      = (cmd_i.step == StepWgAcc) ||
                     (((cmd_i.step == StepUpdWr) || (cmd_i.step == StepGClr)) && col_in);
  assign div_start = cmd_i.step == StepUpdDiv;

  dslt_div #(
    .NUM_W (NumW),
    .DEN_W (DenW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (den),
    .quo_o   (quo),
    .done_o  (div_done)
  );

  assign status_o.div_done = div_done;

  // weight memory
  always_ff @(posedge clk_i) begin
    if (w_we) wmem[addr] <= (cmd_i.step == StepLoadW) ? value_q : new_w;
    if ((cmd_i.step == StepRdW) || ((cmd_i.step == StepUpdRd) && col_in)) begin
      w_rd_q <= wmem[addr];
    end
  end

  // gradient memory
  always_ff @(posedge clk_i) begin
    if (g_we) begin
      gmem[addr] <= (cmd_i.step == StepWgAcc) ?
                    sat32(64'(g_rd_q) + rnd_frac(64'(prod_q), FRAC_BITS)) : '0;
    end
    if ((cmd_i.step == StepRdG) || ((cmd_i.step == StepUpdRd) && col_in)) begin
      g_rd_q <= gmem[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.step)
      StepLatch: begin
        value_q <= value_i;
        cnt_q   <= (sample_count_i == '0) ? 16'd1 : sample_count_i;
        sum_q   <= '0;
      end
      StepLoadB:  bias_q[r] <= value_q;
      StepFwdMul: prod_q <= w_rd_q * value_q;
      StepErrS:   prod_q <= $signed(s_ext * (32'(1 << FRAC_BITS) - s_ext));
      StepErrD:   prod_q <= 32'(value_q) * 32'(d_val);
      StepWgMul:  prod_q <= value_q * delta_q[r];
      StepPeMul:  prod_q <= w_rd_q * delta_q[r];
      StepPeAcc:  sum_q <= sum_q + 40'(prod_q);
      StepUpdMul: upd_p_q <= $signed({1'b0, cmd_i.lr}) * g_sel;
      StepUpdWr: begin
        if (col_bias) bias_q[r] <= new_w;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step == StepFinOut) begin
      res_value_q <= $signed(s_val);
      res_index_q <= cmd_i.row[3:0];
      res_last_q  <= cmd_i.flag;
    end else if (cmd_i.step == StepPeOut) begin
      res_value_q <= sat16(rnd_frac(64'(sum_q), FRAC_BITS));
      res_index_q <= cmd_i.col[3:0];
      res_last_q  <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      for (int k = 0; k < OUT_MAX; k++) begin
        acc_q[k]   <= '0;
        z_q[k]     <= '0;
        delta_q[k] <= '0;
        bg_q[k]    <= '0;
      end
    end else begin
      res_valid_q <= (cmd_i.step == StepFinOut) || (cmd_i.step == StepPeOut);
      case (cmd_i.step)
        StepFwdAcc: acc_q[r] <= sat32(64'(acc_q[r]) + rnd_frac(64'(prod_q), FRAC_BITS));
        StepFinZ:   z_q[r] <= sat16(64'(acc_q[r]) + 64'(bias_q[r]));
        StepFinClr: begin
          for (int k = 0; k < OUT_MAX; k++) acc_q[k] <= '0;
        end
        StepErrW:   delta_q[r] <= sat16(rnd_frac(64'(prod_q), FRAC_BITS));
        StepBg: begin
          for (int k = 0; k < OUT_MAX; k++) begin
            if (k < int'(cmd_i.nout)) bg_q[k] <= sat32(64'(bg_q[k]) + 64'(delta_q[k]));
          end
        end
        StepBgClr: begin
          for (int k = 0; k < OUT_MAX; k++) bg_q[k] <= '0;
        end
        default: ;
      endcase
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_value_o = res_value_q;
  assign result_index_o = res_index_q;
  assign result_last_o  = res_last_q;

endmodule

// ----- rtl/core/dslt_ctrl.sv -----
// ---------------------------------------------------------------------------
// dslt_ctrl
// Configuration registers and the sequencer that steps the datapath through
// each operation.
// ---------------------------------------------------------------------------
module dslt_ctrl #(
  parameter int unsigned IN_MAX  = 16,
  parameter int unsigned OUT_MAX = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [14:0]          cfg_data_i,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [2:0]           opcode_i,
  input  logic [3:0]           row_i,
  input  logic [3:0]           col_i,
  input  logic                 last_i,
  output dslt_pkg::cmd_t       cmd_o,
  input  dslt_pkg::status_t    status_i
);
  import dslt_pkg::*;

  localparam int unsigned EffIn  = (IN_MAX < NodeCap) ? IN_MAX : NodeCap;
  localparam int unsigned EffOut = (OUT_MAX < NodeCap) ? OUT_MAX : NodeCap;

  localparam logic [4:0] ST_CLR   = 5'd0;
  localparam logic [4:0] ST_IDLE  = 5'd1;
  localparam logic [4:0] ST_LDW   = 5'd2;
  localparam logic [4:0] ST_LDB   = 5'd3;
  localparam logic [4:0] ST_FRD   = 5'd4;
  localparam logic [4:0] ST_FMUL  = 5'd5;
  localparam logic [4:0] ST_FACC  = 5'd6;
  localparam logic [4:0] ST_FZ    = 5'd7;
  localparam logic [4:0] ST_FOUT  = 5'd8;
  localparam logic [4:0] ST_FCLR  = 5'd9;
  localparam logic [4:0] ST_ES    = 5'd10;
  localparam logic [4:0] ST_ED    = 5'd11;
  localparam logic [4:0] ST_EW    = 5'd12;
  localparam logic [4:0] ST_GRD   = 5'd13;
  localparam logic [4:0] ST_GMUL  = 5'd14;
  localparam logic [4:0] ST_GACC  = 5'd15;
  localparam logic [4:0] ST_BG    = 5'd16;
  localparam logic [4:0] ST_PRD   = 5'd17;
  localparam logic [4:0] ST_PMUL  = 5'd18;
  localparam logic [4:0] ST_PACC  = 5'd19;
  localparam logic [4:0] ST_POUT  = 5'd20;
  localparam logic [4:0] ST_URD   = 5'd21;
  localparam logic [4:0] ST_UMUL  = 5'd22;
  localparam logic [4:0] ST_UDIV  = 5'd23;
  localparam logic [4:0] ST_UWAIT = 5'd24;
  localparam logic [4:0] ST_UWR   = 5'd25;
  localparam logic [4:0] ST_UCLR  = 5'd26;
  localparam logic [4:0] ST_UBG   = 5'd27;

  logic [4:0]  state_q, state_d;
  logic [5:0]  i_q, i_d;
  logic [6:0]  j_q, j_d;
  logic [4:0]  in_size_q, out_size_q;
  logic [14:0] lr_q;
  logic [3:0]  item_row_q, item_col_q;
  logic        last_q;
  logic [4:0]  nin, nout;
  logic        accept;
  logic        row_end;
  logic        upd_use;

  assign nin  = (in_size_q > 5'(EffIn)) ? 5'(EffIn) : in_size_q;
  assign nout = (out_size_q > 5'(EffOut)) ? 5'(EffOut) : out_size_q;

  assign busy_o  = state_q != ST_IDLE;
  assign accept  = start_i && !busy_o;
  assign row_end = (7'(i_q) + 7'd1) == 7'(nout);
  assign upd_use = (7'(i_q) < 7'(nout)) && ((j_q < 7'(nin)) || (j_q == 7'(IN_MAX)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_size_q  <= 5'd16;
      out_size_q <= 5'd16;
      lr_q       <= 15'd410;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgInSize:    in_size_q  <= cfg_data_i[4:0];
        CfgOutSize:   out_size_q <= cfg_data_i[4:0];
        CfgLearnRate: lr_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_row_q <= row_i;
      item_col_q <= col_i;
      last_q     <= last_i;
    end
  end

  always_comb begin
    state_d    = state_q;
    i_d        = i_q;
    j_d        = j_q;
    cmd_o.step = StepNone;
    cmd_o.row  = i_q;
    cmd_o.col  = 7'(item_col_q);
    cmd_o.flag = 1'b0;
    cmd_o.nout = nout;
    cmd_o.lr   = lr_q;
    unique case (state_q)
      ST_CLR: begin
        cmd_o.step = StepGClr;
        cmd_o.col  = j_q;
        if (j_q == 7'(IN_MAX - 1)) begin
          j_d = '0;
          if (i_q == 6'(OUT_MAX - 1)) begin
            i_d     = '0;
            state_d = ST_IDLE;
          end else begin
            i_d = i_q + 1'b1;
          end
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_o.step = StepLatch;
          i_d        = '0;
          j_d        = '0;
          case (opcode_i)
            OpLoadWeight: begin
              state_d = ((32'(row_i) < OUT_MAX) && (32'(col_i) < IN_MAX)) ? ST_LDW : ST_IDLE;
            end
            OpLoadBias: state_d = (32'(row_i) < OUT_MAX) ? ST_LDB : ST_IDLE;
            OpForward: begin
              if ((5'(col_i) < nin) && (nout != '0)) state_d = ST_FRD;
              else if (last_i) state_d = (nout != '0) ? ST_FZ : ST_FCLR;
              else state_d = ST_IDLE;
            end
            OpOutError: state_d = (5'(row_i) < nout) ? ST_ES : ST_IDLE;
            OpPrevAct: begin
              if ((5'(col_i) < nin) && (nout != '0)) state_d = ST_GRD;
              else state_d = last_i ? ST_BG : ST_IDLE;
            end
            OpReadError: begin
              state_d = ((5'(col_i) < nin) && (nout != '0)) ? ST_PRD : ST_POUT;
            end
            OpUpdate: state_d = ST_URD;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_LDW: begin
        cmd_o.step = StepLoadW;
        cmd_o.row  = 6'(item_row_q);
        state_d    = ST_IDLE;
      end
      ST_LDB: begin
        cmd_o.step = StepLoadB;
        cmd_o.row  = 6'(item_row_q);
        state_d    = ST_IDLE;
      end
      ST_FRD: begin
        cmd_o.step = StepRdW;
        state_d    = ST_FMUL;
      end
      ST_FMUL: begin
        cmd_o.step = StepFwdMul;
        state_d    = ST_FACC;
      end
      ST_FACC: begin
        cmd_o.step = StepFwdAcc;
        if (row_end) begin
          i_d     = '0;
          state_d = last_q ? ST_FZ : ST_IDLE;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = ST_FRD;
        end
      end
      ST_FZ: begin
        cmd_o.step = StepFinZ;
        state_d    = ST_FOUT;
      end
      ST_FOUT: begin
        cmd_o.step = StepFinOut;
        cmd_o.flag = row_end;
        if (row_end) begin
          state_d = ST_FCLR;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = ST_FZ;
        end
      end
      ST_FCLR: begin
        cmd_o.step = StepFinClr;
        state_d    = ST_IDLE;
      end
      ST_ES: begin
        cmd_o.step = StepErrS;
        cmd_o.row  = 6'(item_row_q);
        state_d    = ST_ED;
      end
      ST_ED: begin
        cmd_o.step = StepErrD;
        cmd_o.row  = 6'(item_row_q);
        state_d    = ST_EW;
      end
      ST_EW: begin
        cmd_o.step = StepErrW;
        cmd_o.row  = 6'(item_row_q);
        state_d    = ST_IDLE;
      end
      ST_GRD: begin
        cmd_o.step = StepRdG;
        state_d    = ST_GMUL;
      end
      ST_GMUL: begin
        cmd_o.step = StepWgMul;
        state_d    = ST_GACC;
      end
      ST_GACC: begin
        cmd_o.step = StepWgAcc;
        if (row_end) begin
          state_d = last_q ? ST_BG : ST_IDLE;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = ST_GRD;
        end
      end
      ST_BG: begin
        cmd_o.step = StepBg;
        state_d    = ST_IDLE;
      end
      ST_PRD: begin
        cmd_o.step = StepRdW;
        state_d    = ST_PMUL;
      end
      ST_PMUL: begin
        cmd_o.step = StepPeMul;
        state_d    = ST_PACC;
      end
      ST_PACC: begin
        cmd_o.step = StepPeAcc;
        if (row_end) begin
          state_d = ST_POUT;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = ST_PRD;
        end
      end
      ST_POUT: begin
        cmd_o.step = StepPeOut;
        state_d    = ST_IDLE;
      end
      ST_URD: begin
        cmd_o.step = StepUpdRd;
        cmd_o.col  = j_q;
        state_d    = upd_use ? ST_UMUL : ST_UCLR;
      end
      ST_UMUL: begin
        cmd_o.step = StepUpdMul;
        cmd_o.col  = j_q;
        state_d    = ST_UDIV;
      end
      ST_UDIV: begin
        cmd_o.step = StepUpdDiv;
        cmd_o.col  = j_q;
        state_d    = ST_UWAIT;
      end
      ST_UWAIT: begin
        cmd_o.col = j_q;
        if (status_i.div_done) state_d = ST_UWR;
      end
      ST_UWR, ST_UCLR: begin
        cmd_o.step = (state_q == ST_UWR) ? StepUpdWr : StepGClr;
        cmd_o.col  = j_q;
        state_d    = ST_URD;
        if (j_q == 7'(IN_MAX)) begin
          j_d = '0;
          if (i_q == 6'(OUT_MAX - 1)) state_d = ST_UBG;
          else i_d = i_q + 1'b1;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      ST_UBG: begin
        cmd_o.step = StepBgClr;
        state_d    = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  a_fwd_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FRD) |-> (7'(i_q) < 7'(nout)))
    else $error("forward row beyond nodes in use");

  a_div_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UWAIT && !status_i.div_done) |=> (state_q == ST_UWAIT))
    else $error("left divide wait early");

  a_upd_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_URD) |-> (j_q <= 7'(IN_MAX)))
    else $error("update column out of range");

endmodule

// ----- rtl/core/dense_sigmoid_layer_trainer.sv -----
// ---------------------------------------------------------------------------
// dense_sigmoid_layer_trainer
// Dense layer with sigmoid activation and batch gradient descent, Q3.12.
//
// Commands go in on start_i with opcode_i, row_i, col_i, value_i, last_i and
// sample_count_i; a command is taken when start_i is high and busy_o is low.
// Results leave on result_valid_o, one cycle each, with no back pressure.
// The user writes registers through cfg_we_i / cfg_idx_i / cfg_data_i while
// idle; the block itself does not enforce this.
// A forward element walks the n active output rows; the last element also
// yields n results. A previous-activation element walks the same rows, and
// the last one adds the deltas to the bias gradients. A read back error sums
// over the rows and gives one result. An update sweeps the full OUT_MAX x
// (IN_MAX+1) grid, with a serial divide per active weight or bias and a clear
// per unused slot. Work within a command is serialised by the shared product
// register and the single memory port per store. After reset busy_o stays
// high while the gradient memory is cleared; registers take effect at once.
// ---------------------------------------------------------------------------
module dense_sigmoid_layer_trainer #(
  parameter int unsigned IN_MAX    = 16,
  parameter int unsigned OUT_MAX   = 16,
  parameter int unsigned FRAC_BITS = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [14:0]        cfg_data_i,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [2:0]         opcode_i,
  input  logic [3:0]         row_i,
  input  logic [3:0]         col_i,
  input  logic signed [15:0] value_i,
  input  logic               last_i,
  input  logic [15:0]        sample_count_i,
  output logic               result_valid_o,
  output logic signed [15:0] result_value_o,
  output logic [3:0]         result_index_o,
  output logic               result_last_o
);
  import dslt_pkg::*;

  cmd_t    cmd;
  status_t status;

  dslt_ctrl #(
    .IN_MAX  (IN_MAX),
    .OUT_MAX (OUT_MAX)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .opcode_i   (opcode_i),
    .row_i      (row_i),
    .col_i      (col_i),
    .last_i     (last_i),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  dslt_datapath #(
    .IN_MAX    (IN_MAX),
    .OUT_MAX   (OUT_MAX),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .value_i        (value_i),
    .sample_count_i (sample_count_i),
    .result_valid_o (result_valid_o),
    .result_value_o (result_value_o),
    .result_index_o (result_index_o),
    .result_last_o  (result_last_o)
  );

endmodule
